// ----- hdl/bfsu_pkg.sv -----
package bfsu_pkg;

    // Frame geometry: one cell per slot, one top and one bottom motor per cell.
    localparam int CELLS  = 10;
    localparam int CHAN_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    // Calibration ROM geometry.
    localparam int CAL_ROWS = 10;
    localparam int CAL_COLS = 9;

    // Pulse conversion: on-count = pulse_us * resolution * frame rate / 1e6.
    localparam longint unsigned PWM_RESOLUTION = 4096;
    localparam longint unsigned SERVO_HZ       = 50;
    localparam longint unsigned US_PER_S       = 1000000;

    localparam logic [3:0] UNKNOWN_STATE     = 4'd15;
    localparam logic [3:0] CHANGES_MAX       = 4'd15;
    localparam logic [3:0] BATCH_LIMIT_RESET = 4'd4;

    // Result kinds.
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_PAUSE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    typedef logic [0:1][0:CAL_ROWS-1][0:CAL_COLS-1][11:0] cal_table_t;

    localparam cal_table_t CAL_PULSE_US = '{
        '{
            '{12'd513, 12'd674, 12'd1001, 12'd1191, 12'd1558, 12'd1729, 12'd1997, 12'd2183, 12'd2358},
            '{12'd513, 12'd781, 12'd1030, 12'd1270, 12'd1587, 12'd1797, 12'd2046, 12'd2261, 12'd2437},
            '{12'd513, 12'd752, 12'd986,  12'd1167, 12'd1519, 12'd1704, 12'd2021, 12'd2231, 12'd2461},
            '{12'd513, 12'd586, 12'd957,  12'd1079, 12'd1475, 12'd1582, 12'd2011, 12'd2163, 12'd2329},
            '{12'd513, 12'd728, 12'd1001, 12'd1192, 12'd1470, 12'd1719, 12'd2080, 12'd2207, 12'd2422},
            '{12'd513, 12'd640, 12'd923,  12'd1099, 12'd1450, 12'd1675, 12'd1982, 12'd2168, 12'd2391},
            '{12'd513, 12'd718, 12'd1055, 12'd1279, 12'd1558, 12'd1787, 12'd2080, 12'd2310, 12'd2554},
            '{12'd513, 12'd693, 12'd952,  12'd1118, 12'd1421, 12'd1680, 12'd1973, 12'd2173, 12'd2446},
            '{12'd513, 12'd751, 12'd977,  12'd1201, 12'd1533, 12'd1831, 12'd2026, 12'd2280, 12'd2554},
            '{12'd513, 12'd605, 12'd1006, 12'd1133, 12'd1455, 12'd1727, 12'd2021, 12'd2153, 12'd2437}
        },
        '{
            '{12'd513, 12'd723, 12'd972,  12'd1118, 12'd1485, 12'd1689, 12'd2002, 12'd2222, 12'd2480},
            '{12'd513, 12'd723, 12'd972,  12'd1201, 12'd1553, 12'd1831, 12'd2134, 12'd2280, 12'd2480},
            '{12'd513, 12'd835, 12'd1050, 12'd1270, 12'd1616, 12'd1885, 12'd2075, 12'd2370, 12'd2431},
            '{12'd513, 12'd659, 12'd889,  12'd1162, 12'd1489, 12'd1774, 12'd2075, 12'd2319, 12'd2518},
            '{12'd513, 12'd864, 12'd1133, 12'd1396, 12'd1636, 12'd1963, 12'd2236, 12'd2422, 12'd2598},
            '{12'd513, 12'd762, 12'd1040, 12'd1287, 12'd1533, 12'd1880, 12'd2168, 12'd2314, 12'd2529},
            '{12'd513, 12'd711, 12'd1060, 12'd1240, 12'd1646, 12'd1934, 12'd2163, 12'd2339, 12'd2588},
            '{12'd513, 12'd718, 12'd996,  12'd1161, 12'd1455, 12'd1836, 12'd2163, 12'd2295, 12'd2515},
            '{12'd513, 12'd840, 12'd1152, 12'd1362, 12'd1636, 12'd1938, 12'd2236, 12'd2432, 12'd2588},
            '{12'd513, 12'd664, 12'd947,  12'd1147, 12'd1396, 12'd1694, 12'd2036, 12'd2202, 12'd2432}
        }
    };

    // Converts the whole calibration ROM to on-counts at elaboration.
    function automatic cal_table_t build_pwm_table();
        cal_table_t      t;
        longint unsigned us;
        t = '0;
        for (int c = 0; c < 2; c++)
        begin
            for (int r = 0; r < CAL_ROWS; r++)
            begin
                for (int s = 0; s < CAL_COLS; s++)
                begin
                    us         = longint'(CAL_PULSE_US[c][r][s]);
                    t[c][r][s] = 12'((us * PWM_RESOLUTION * SERVO_HZ) / US_PER_S);
                end
            end
        end
        return t;
    endfunction

    localparam cal_table_t PWM_TABLE = build_pwm_table();

    // Channels past the last calibrated row share that row.
    function automatic logic [11:0] pwm_for(logic ctrl, logic [3:0] chan, logic [2:0] st);
        logic [3:0] row;
        row = (int'(chan) < CAL_ROWS) ? chan : 4'(CAL_ROWS - 1);
        return PWM_TABLE[ctrl][row][st];
    endfunction

endpackage

// ----- hdl/bfsu_if.sv -----
interface bfsu_item_if;
    logic       valid;
    logic       ready;
    logic [3:0] slot;
    logic [5:0] dots;
    logic       top_write_ok;
    logic       bottom_write_ok;

    modport source (output valid, output slot, output dots, output top_write_ok,
                    output bottom_write_ok, input ready);
    modport sink   (input valid, input slot, input dots, input top_write_ok,
                    input bottom_write_ok, output ready);
endinterface

interface bfsu_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        controller;
    logic [3:0]  channel;
    logic [11:0] pwm_on;
    logic        write_accepted;
    logic        frame_applied;
    logic [31:0] failure_count;
    logic        last_of_run;

    modport source (output valid, output kind, output controller, output channel,
                    output pwm_on, output write_accepted, output frame_applied,
                    output failure_count, output last_of_run, input ready);
    modport sink   (input valid, input kind, input controller, input channel,
                    input pwm_on, input write_accepted, input frame_applied,
                    input failure_count, input last_of_run, output ready);
endinterface

interface bfsu_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] batch_limit;

    modport source (output valid, output batch_limit, input ready);
    modport sink   (input valid, input batch_limit, output ready);
endinterface

// ----- hdl/braille_frame_servo_updater_core.sv -----
// Braille frame servo updater.
// The item channel takes one six-dot braille cell per word, tagged with its slot in
// the frame (slot 0 opens a frame, the last slot closes it). The result channel gives
// up to four words per cell, in order: top servo write, bottom servo write, settling
// pause and frame status; last_of_run marks the final word of a cell. A cell whose
// motors already hold the requested states, and which causes no pause and is not the
// last slot, gives no word at all; a slot past the end of the frame is dropped.
// The cfg channel writes the batch limit and is ready outside reset; write it only while idle.
// The first result word of a cell passes through the cell buffer and then the output register.
// Throughput: one result word per cycle while the receiver is ready; a cell gives one to four
// words, and a cell that needs nothing gives none. The single output register sets that
// rate. A cell is taken while the previous cell's last word is moving to the output register,
// so cells with one word each stream at one per cycle.
// A stalled receiver holds the output register; cells that give no word are still taken,
// and the first cell that gives a word is parked in the cell buffer, after which the item
// channel drops ready.
// Reset marks every motor state unknown, clears the failure and change counts, sets the
// frame as applied, loads a batch limit of four and empties both buffers. Both ready
// lines stay low during reset and rise once the live register is set after its release.
module braille_frame_servo_updater_core (
    input logic            clk,
    input logic            rst_n,
    bfsu_item_if.sink      item,
    bfsu_result_if.source  result,
    bfsu_cfg_if.sink       cfg
);

    // One-hot positions of the four possible words of a cell within the cell buffer.
    localparam logic [3:0] SEL_TOP    = 4'b0001;
    localparam logic [3:0] SEL_BOTTOM = 4'b0010;
    localparam logic [3:0] SEL_PAUSE  = 4'b0100;
    localparam logic [3:0] SEL_STATUS = 4'b1000;

    // Block state carried from cell to cell.
    logic        live_reg;
    logic [3:0]  batch_limit_reg;
    logic [3:0]  top_cache_reg [bfsu_pkg::CELLS];
    logic [3:0]  bot_cache_reg [bfsu_pkg::CELLS];
    logic [31:0] fail_reg;
    logic [3:0]  chg_reg;
    logic        frame_ok_reg;

    // Cell buffer: everything needed to emit the words of one accepted cell.
    logic [3:0]  mask_reg;
    logic [3:0]  mask_next;
    logic [11:0] top_pwm_reg;
    logic [11:0] bot_pwm_reg;
    logic        top_acc_reg;
    logic        bot_acc_reg;
    logic [31:0] top_fail_reg;
    logic [31:0] bot_fail_reg;
    logic [3:0]  chan_reg;
    logic        applied_reg;

    // Output register.
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  out_kind_reg;
    logic        out_ctrl_reg;
    logic [3:0]  out_chan_reg;
    logic [11:0] out_pwm_reg;
    logic        out_acc_reg;
    logic        out_applied_reg;
    logic [31:0] out_fail_reg;
    logic        out_last_reg;

    // Cell evaluation.
    logic                        accept;
    logic                        slot_ok;
    logic [3:0]                  chan_full;
    logic [bfsu_pkg::CHAN_W-1:0] chan_idx;
    logic [3:0]                  top_target;
    logic [3:0]                  bot_state;
    logic                        top_att;
    logic                        bot_att;
    logic                        top_fail;
    logic                        bot_fail;
    logic                        frame_start;
    logic [3:0]                  chg_base;
    logic [3:0]                  chg_a;
    logic [3:0]                  chg_b;
    logic                        ok_base;
    logic [31:0]                 fail_a;
    logic [31:0]                 fail_b;
    logic                        pause;
    logic                        status;
    logic [3:0]                  new_mask;

    // Word selection.
    logic [3:0]  pick;
    logic [3:0]  rest;
    logic        out_load;
    logic        move;
    logic [1:0]  sel_kind;
    logic        sel_ctrl;
    logic [3:0]  sel_chan;
    logic [11:0] sel_pwm;
    logic        sel_acc;
    logic        sel_applied;
    logic [31:0] sel_fail;

    assign cfg.ready = live_reg;

    // The motor states requested by this cell. The bottom row reads dots 4, 5, 6 as
    // its state bits from most to least significant.
    always_comb
    begin
        accept      = item.valid & item.ready;
        slot_ok     = 5'(item.slot) < 5'(bfsu_pkg::CELLS);
        chan_full   = 4'(bfsu_pkg::CELLS - 1) - item.slot;
        chan_idx    = chan_full[bfsu_pkg::CHAN_W-1:0];
        top_target  = {1'b0, item.dots[2:0]};
        bot_state   = {1'b0, item.dots[3], item.dots[4], item.dots[5]};
        frame_start = (item.slot == 4'd0);

        // A write is attempted only when the cached state differs; an unknown cache
        // entry differs from every state.
        top_att  = (top_cache_reg[chan_idx] != top_target);
        bot_att  = (bot_cache_reg[chan_idx] != bot_state);
        top_fail = top_att & ~item.top_write_ok;
        bot_fail = bot_att & ~item.bottom_write_ok;

        // A new frame restarts the change count and the applied flag.
        chg_base = frame_start ? 4'd0 : chg_reg;
        ok_base  = frame_start ? 1'b1 : frame_ok_reg;

        // The change count saturates rather than wrapping.
        chg_a = (top_att && chg_base != bfsu_pkg::CHANGES_MAX) ? chg_base + 4'd1 : chg_base;
        chg_b = (bot_att && chg_a != bfsu_pkg::CHANGES_MAX) ? chg_a + 4'd1 : chg_a;

        fail_a = fail_reg + 32'(top_fail);
        fail_b = fail_a + 32'(bot_fail);

        pause    = (chg_b >= batch_limit_reg);
        status   = (item.slot == 4'(bfsu_pkg::CELLS - 1));
        new_mask = {status, pause, bot_att, top_att};
    end

    // The lowest pending word goes next; it is the last of its cell when nothing
    // remains behind it.
    always_comb
    begin
        pick     = mask_reg & (~mask_reg + 4'd1);
        rest     = mask_reg & ~pick;
        out_load = ~out_valid_reg | result.ready;
        move     = out_load & (|mask_reg);
    end

    // A new cell may enter when the buffer is empty or its last word leaves now.
    assign item.ready = live_reg & ((mask_reg == 4'd0) | (move & (rest == 4'd0)));

    always_comb
    begin
        mask_next = mask_reg;
        if (move)
        begin
            mask_next = rest;
        end
        if (accept)
        begin
            mask_next = slot_ok ? new_mask : 4'd0;
        end

        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Payload of the selected word. Pause and status report the failure count after
    // both writes of the cell.
    always_comb
    begin
        sel_kind    = bfsu_pkg::KIND_WRITE;
        sel_ctrl    = 1'b0;
        sel_chan    = 4'd0;
        sel_pwm     = 12'd0;
        sel_acc     = 1'b0;
        sel_applied = 1'b0;
        sel_fail    = bot_fail_reg;
        unique case (pick)
            SEL_TOP:
            begin
                sel_chan = chan_reg;
                sel_pwm  = top_pwm_reg;
                sel_acc  = top_acc_reg;
                sel_fail = top_fail_reg;
            end
            SEL_BOTTOM:
            begin
                sel_ctrl = 1'b1;
                sel_chan = chan_reg;
                sel_pwm  = bot_pwm_reg;
                sel_acc  = bot_acc_reg;
            end
            SEL_PAUSE:
            begin
                sel_kind = bfsu_pkg::KIND_PAUSE;
            end
            SEL_STATUS:
            begin
                sel_kind    = bfsu_pkg::KIND_STATUS;
                sel_applied = applied_reg;
            end
            default:
            begin
                sel_kind = bfsu_pkg::KIND_WRITE;
            end
        endcase
    end

    // Control and block state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg        <= 1'b0;
            batch_limit_reg <= bfsu_pkg::BATCH_LIMIT_RESET;
            fail_reg        <= 32'd0;
            chg_reg         <= 4'd0;
            frame_ok_reg    <= 1'b1;
            mask_reg        <= 4'd0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < bfsu_pkg::CELLS; i++)
            begin
                top_cache_reg[i] <= bfsu_pkg::UNKNOWN_STATE;
                bot_cache_reg[i] <= bfsu_pkg::UNKNOWN_STATE;
            end
        end
        else
        begin
            live_reg      <= 1'b1;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                batch_limit_reg <= cfg.batch_limit;
            end
            if (accept && slot_ok)
            begin
                fail_reg     <= fail_b;
                chg_reg      <= pause ? 4'd0 : chg_b;
                frame_ok_reg <= ok_base & ~top_fail & ~bot_fail;
                // Only an acknowledged write updates the cached motor state.
                if (top_att && item.top_write_ok)
                begin
                    top_cache_reg[chan_idx] <= top_target;
                end
                if (bot_att && item.bottom_write_ok)
                begin
                    bot_cache_reg[chan_idx] <= bot_state;
                end
            end
        end
    end

    // Payload registers of the cell buffer and the output stage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_pwm_reg  <= bfsu_pkg::pwm_for(1'b0, chan_full, top_target[2:0]);
            bot_pwm_reg  <= bfsu_pkg::pwm_for(1'b1, chan_full, bot_state[2:0]);
            top_acc_reg  <= item.top_write_ok;
            bot_acc_reg  <= item.bottom_write_ok;
            top_fail_reg <= fail_a;
            bot_fail_reg <= fail_b;
            chan_reg     <= chan_full;
            applied_reg  <= ok_base & ~top_fail & ~bot_fail;
        end
        if (move)
        begin
            out_kind_reg    <= sel_kind;
            out_ctrl_reg    <= sel_ctrl;
            out_chan_reg    <= sel_chan;
            out_pwm_reg     <= sel_pwm;
            out_acc_reg     <= sel_acc;
            out_applied_reg <= sel_applied;
            out_fail_reg    <= sel_fail;
            out_last_reg    <= (rest == 4'd0);
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.kind           = out_kind_reg;
    assign result.controller     = out_ctrl_reg;
    assign result.channel        = out_chan_reg;
    assign result.pwm_on         = out_pwm_reg;
    assign result.write_accepted = out_acc_reg;
    assign result.frame_applied  = out_applied_reg;
    assign result.failure_count  = out_fail_reg;
    assign result.last_of_run    = out_last_reg;

`ifndef SYNTH
    // A new cell is only taken when at most one word of the previous one is pending.
    a_ready_buffer: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> $countones(mask_reg) <= 1)
        else $error("cell taken while several words still pending");

    // The frame status word always closes the words of its cell.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.kind == bfsu_pkg::KIND_STATUS) |-> result.last_of_run)
        else $error("frame status word not marked last");

    // One cell can add at most two refused writes.
    a_fail_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (fail_reg == $past(fail_reg)) || (fail_reg == $past(fail_reg) + 32'd1)
                 || (fail_reg == $past(fail_reg) + 32'd2))
        else $error("failure count jumped by more than two");

    // Writes only target channels of the frame.
    a_write_chan: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.kind == bfsu_pkg::KIND_WRITE)
        |-> 5'(result.channel) < 5'(bfsu_pkg::CELLS))
        else $error("write to a channel outside the frame");
`endif

endmodule
